@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`endif

@@ sv/pec_pkg.sv @@
package pec_pkg;

  localparam int unsigned RING_CAPACITY_DEF = 15;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned NUM_STATS = 10;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_DRAIN  = 3'd1,
    OP_SEED   = 3'd2,
    OP_EXPECT = 3'd3,
    OP_STAT   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_PUSH  = 3'd0,
    KIND_EDIT  = 3'd1,
    KIND_DRAIN = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_STAT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    EV_BEGIN = 2'd0,
    EV_END   = 2'd1,
    EV_VALUE = 2'd2,
    EV_NONE  = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    REG_QUIET    = 2'd0,
    REG_LIFETIME = 2'd1,
    REG_TOL      = 2'd2
  } reg_e;

  // Statistic counter slots.
  localparam int unsigned ST_PUSHED   = 0;
  localparam int unsigned ST_DROPPED  = 1;
  localparam int unsigned ST_EDITS    = 2;
  localparam int unsigned ST_IMPLICIT = 3;
  localparam int unsigned ST_EXPIRED  = 4;
  localparam int unsigned ST_SBEGIN   = 5;
  localparam int unsigned ST_SEND     = 6;
  localparam int unsigned ST_ECHOES   = 7;
  localparam int unsigned ST_UNSEEDED = 8;
  localparam int unsigned ST_ABSORBED = 9;

  typedef enum logic [2:0] {
    C_NOP,
    C_ALLOC,
    C_EXPIRE,
    C_BEGIN,
    C_CLOSE,
    C_ECHO,
    C_VALUE,
    C_SEED_EXP
  } cell_op_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         event_kind;
    logic [31:0]        device_id;
    logic [15:0]        param_index;
    logic signed [31:0] param_value;
    logic [47:0]        now_ms;
    logic               absorb;
    logic [3:0]         stat_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               accepted;
    logic               table_full;
    logic [31:0]        edit_device;
    logic [15:0]        edit_param;
    logic signed [31:0] before_value;
    logic signed [31:0] after_value;
    logic               implicit_edit;
    logic [31:0]        number;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] quiet;
    logic [31:0] lifetime;
    logic [30:0] tol;
  } cfg_t;

  typedef struct packed {
    cell_op_e           op;
    logic               expect_sel;
    logic [47:0]        key;
    logic signed [31:0] val;
    logic [47:0]        now;
  } cell_cmd_t;

  typedef struct packed {
    logic               valid;
    logic               known;
    logic               guard;
    logic               open;
    logic               impl;
    logic               hasv;
    logic [47:0]        key;
    logic signed [31:0] prior;
    logic signed [31:0] after;
    logic               expired;
    logic               echo_hit;
    logic               quiet_done;
    logic               unseeded;
  } cell_stat_t;

  function automatic logic [47:0] elapsed(input logic [47:0] now, input logic [47:0] then);
    return (now >= then) ? (now - then) : 48'd0;
  endfunction

endpackage

@@ sv/pec_cell.sv @@
module pec_cell import pec_pkg::*; #(
  parameter int unsigned TW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [TW-1:0] sel_i,
  input  cell_cmd_t     cmd_i,
  input  cfg_t          cfg_i,
  input  logic          found_i,
  input  logic [TW-1:0] hit_idx_i,
  output logic          found_o,
  output logic [TW-1:0] hit_idx_o,
  output cell_stat_t    stat_o
);

  logic valid_q, known_q, guard_q, open_q, impl_q, hasv_q;
  logic [47:0]        key_q;
  logic signed [31:0] last_q, before_q, after_q, echo_q;
  logic [47:0]        armed_q, lastval_q;

  logic              me, hit;
  logic signed [32:0] diff;
  logic [32:0]       adiff;

  assign me  = (sel_i == TW'(IDX));
  assign hit = valid_q && (key_q == cmd_i.key);

  // The first matching cell claims the key; later cells pass it on.
  assign found_o   = found_i || hit;
  assign hit_idx_o = found_i ? hit_idx_i : TW'(IDX);

  assign diff  = 33'(cmd_i.val) - 33'(echo_q);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    stat_o            = '0;
    stat_o.valid      = valid_q;
    stat_o.known      = known_q;
    stat_o.guard      = guard_q;
    stat_o.open       = open_q;
    stat_o.impl       = impl_q;
    stat_o.hasv       = hasv_q;
    stat_o.key        = key_q;
    stat_o.prior      = before_q;
    stat_o.after      = after_q;
    stat_o.expired    = guard_q && (elapsed(cmd_i.now, armed_q) > {16'd0, cfg_i.lifetime});
    stat_o.echo_hit   = guard_q && !open_q && (adiff <= {2'b00, cfg_i.tol});
    stat_o.quiet_done = elapsed(cmd_i.now, lastval_q) >= {16'd0, cfg_i.quiet};
    stat_o.unseeded   = !(open_q && hasv_q) && !known_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      known_q <= 1'b0;
      guard_q <= 1'b0;
      open_q  <= 1'b0;
      impl_q  <= 1'b0;
      hasv_q  <= 1'b0;
    end else if (me) begin
      case (cmd_i.op)
        C_ALLOC: begin
          valid_q <= 1'b1;
          known_q <= 1'b0;
          guard_q <= 1'b0;
          open_q  <= 1'b0;
          impl_q  <= 1'b0;
          hasv_q  <= 1'b0;
        end
        C_EXPIRE: begin
          if (stat_o.expired) guard_q <= 1'b0;
        end
        C_BEGIN: begin
          open_q <= 1'b1;
          impl_q <= 1'b0;
          hasv_q <= 1'b0;
        end
        C_CLOSE: begin
          if (hasv_q) known_q <= 1'b1;
          open_q <= 1'b0;
          hasv_q <= 1'b0;
        end
        C_ECHO: begin
          known_q <= 1'b1;
          guard_q <= 1'b0;
        end
        C_VALUE: begin
          if (!open_q) begin
            open_q <= 1'b1;
            impl_q <= 1'b1;
          end
          hasv_q <= 1'b1;
        end
        C_SEED_EXP: begin
          if (cmd_i.expect_sel) guard_q <= 1'b1;
          else known_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (me) begin
      case (cmd_i.op)
        C_ALLOC: key_q <= cmd_i.key;
        C_CLOSE: begin
          if (hasv_q) last_q <= after_q;
        end
        C_ECHO: last_q <= echo_q;
        C_VALUE: begin
          if (!(open_q && hasv_q)) before_q <= known_q ? last_q : cmd_i.val;
          after_q   <= cmd_i.val;
          lastval_q <= cmd_i.now;
        end
        C_SEED_EXP: begin
          if (cmd_i.expect_sel) begin
            echo_q  <= cmd_i.val;
            armed_q <= cmd_i.now;
          end else begin
            last_q <= cmd_i.val;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sv/param_edit_coalescer.sv @@
// Push and statistic read: result registered and shown in the cycle after start, next item accepted at once.
// Seed and expect echo: result follows the key lookup step and, unless the table is full, the table update step.
// Drain: busy until the done result. The expiry walk and the table walk each visit one
//   allocated cell a cycle; the two-step event fold (lookup, then apply) handles each
//   queued event in turn.
// Results are strobed for one cycle and cannot be held off.
// Reset (asynchronous, active low) empties the ring, clears the table and statistics.
module param_edit_coalescer import pec_pkg::*; #(
  parameter int unsigned RING_CAPACITY = RING_CAPACITY_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  input  in_item_t    in_item_i,
  output logic        busy,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  localparam int unsigned RS = RING_CAPACITY + 1;
  localparam int unsigned PW = (RS > 1) ? $clog2(RS) : 1;
  localparam int unsigned TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXPIRE, S_LOOK, S_APPLY, S_WALK, S_DONE, S_OP_APPLY
  } state_e;

  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [TW-1:0] slot_q, slot_d;
  logic [31:0]   nedit_q, nedit_d;
  logic          full_q, full_d;
  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [31:0]   stat_q [NUM_STATS];
  logic [31:0]   stat_d [NUM_STATS];
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  cfg_t          cfg_q;

  logic [47:0] ring_key_q [RS];
  logic [33:0] ring_pay_q [RS];
  logic        ring_we;

  cell_cmd_t     cmd;
  logic [TW-1:0] sel;
  cell_stat_t    cst [TABLE_ENTRIES];
  cell_stat_t    st;
  logic          found_w [TABLE_ENTRIES+1];
  logic [TW-1:0] hidx_w  [TABLE_ENTRIES+1];

  logic [PW-1:0] wp_nx, rp_nx;
  logic [33:0]   cur_pay;
  logic [1:0]    cur_kind;
  logic          drain_mode;

  assign busy        = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign wp_nx    = (wp_q == PW'(RS - 1)) ? '0 : wp_q + 1'b1;
  assign rp_nx    = (rp_q == PW'(RS - 1)) ? '0 : rp_q + 1'b1;
  assign cur_pay  = ring_pay_q[rp_q];
  assign cur_kind = cur_pay[33:32];
  assign drain_mode = (item_q.op == OP_DRAIN);

  assign found_w[0] = 1'b0;
  assign hidx_w[0]  = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pec_cell #(.TW(TW), .IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .sel_i     (sel),
      .cmd_i     (cmd),
      .cfg_i     (cfg_q),
      .found_i   (found_w[g]),
      .hit_idx_i (hidx_w[g]),
      .found_o   (found_w[g+1]),
      .hit_idx_o (hidx_w[g+1]),
      .stat_o    (cst[g])
    );
  end

  assign st = cst[sel];

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    nedit_d     = nedit_q;
    full_d      = full_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    stat_d      = stat_q;
    out_valid_d = 1'b0;
    out_d       = '0;
    ring_we     = 1'b0;
    sel         = slot_q;
    cmd.op         = C_NOP;
    cmd.expect_sel = (item_q.op == OP_EXPECT);
    cmd.key        = drain_mode ? ring_key_q[rp_q] : {item_q.device_id, item_q.param_index};
    cmd.val        = drain_mode ? $signed(cur_pay[31:0]) : item_q.param_value;
    cmd.now        = item_q.now_ms;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = in_item_i;
          case (in_item_i.op)
            OP_PUSH: begin
              out_valid_d = 1'b1;
              out_d.kind  = KIND_PUSH;
              out_d.last  = 1'b1;
              if (wp_nx == rp_q) begin
                stat_d[ST_DROPPED] = stat_q[ST_DROPPED] + 32'd1;
              end else begin
                ring_we = 1'b1;
                wp_d    = wp_nx;
                stat_d[ST_PUSHED] = stat_q[ST_PUSHED] + 32'd1;
                out_d.accepted    = 1'b1;
              end
            end
            OP_DRAIN: begin
              state_d = S_EXPIRE;
              idx_d   = '0;
              nedit_d = '0;
              full_d  = 1'b0;
            end
            OP_SEED, OP_EXPECT: state_d = S_LOOK;
            OP_STAT: begin
              out_valid_d  = 1'b1;
              out_d.kind   = KIND_STAT;
              out_d.last   = 1'b1;
              out_d.number = (in_item_i.stat_index < 4'(NUM_STATS)) ?
                             stat_q[in_item_i.stat_index] : 32'd0;
            end
            default: ;
          endcase
        end
      end

      S_EXPIRE: begin
        if (idx_q < cnt_q) begin
          sel    = idx_q[TW-1:0];
          cmd.op = C_EXPIRE;
          if (st.expired) stat_d[ST_EXPIRED] = stat_q[ST_EXPIRED] + 32'd1;
          idx_d = idx_q + 1'b1;
        end else begin
          idx_d   = '0;
          state_d = (rp_q != wp_q) ? S_LOOK : S_WALK;
        end
      end

      S_LOOK: begin
        if (drain_mode && cur_kind == EV_NONE) begin
          rp_d    = rp_nx;
          state_d = (rp_nx == wp_q) ? S_WALK : S_LOOK;
        end else if (found_w[TABLE_ENTRIES]) begin
          slot_d  = hidx_w[TABLE_ENTRIES];
          state_d = drain_mode ? S_APPLY : S_OP_APPLY;
        end else if (cnt_q == CW'(TABLE_ENTRIES)) begin
          if (drain_mode) begin
            full_d  = 1'b1;
            rp_d    = rp_nx;
            state_d = (rp_nx == wp_q) ? S_WALK : S_LOOK;
          end else begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_ACK;
            out_d.table_full = 1'b1;
            out_d.last       = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          sel     = cnt_q[TW-1:0];
          cmd.op  = C_ALLOC;
          slot_d  = cnt_q[TW-1:0];
          cnt_d   = cnt_q + 1'b1;
          state_d = drain_mode ? S_APPLY : S_OP_APPLY;
        end
      end

      S_APPLY: begin
        case (cur_kind)
          EV_BEGIN: begin
            if (st.open) stat_d[ST_SBEGIN] = stat_q[ST_SBEGIN] + 32'd1;
            else cmd.op = C_BEGIN;
          end
          EV_END: begin
            if (st.open) begin
              cmd.op = C_CLOSE;
              if (st.hasv) begin
                out_valid_d         = 1'b1;
                out_d.kind          = KIND_EDIT;
                out_d.edit_device   = st.key[47:16];
                out_d.edit_param    = st.key[15:0];
                out_d.before_value  = st.prior;
                out_d.after_value   = st.after;
                out_d.implicit_edit = st.impl;
                nedit_d = nedit_q + 32'd1;
                stat_d[ST_EDITS] = stat_q[ST_EDITS] + 32'd1;
                if (st.impl) stat_d[ST_IMPLICIT] = stat_q[ST_IMPLICIT] + 32'd1;
              end
            end else begin
              stat_d[ST_SEND] = stat_q[ST_SEND] + 32'd1;
            end
          end
          EV_VALUE: begin
            if (st.echo_hit) begin
              cmd.op = C_ECHO;
              stat_d[ST_ECHOES] = stat_q[ST_ECHOES] + 32'd1;
            end else begin
              cmd.op = C_VALUE;
              if (st.unseeded) stat_d[ST_UNSEEDED] = stat_q[ST_UNSEEDED] + 32'd1;
            end
          end
          default: ;
        endcase
        rp_d    = rp_nx;
        state_d = (rp_nx == wp_q) ? S_WALK : S_LOOK;
      end

      S_WALK: begin
        if (idx_q < cnt_q) begin
          sel = idx_q[TW-1:0];
          if (st.open && st.impl) begin
            if (item_q.absorb) begin
              cmd.op = C_CLOSE;
              if (st.hasv) stat_d[ST_ABSORBED] = stat_q[ST_ABSORBED] + 32'd1;
            end else if (st.quiet_done) begin
              cmd.op = C_CLOSE;
              if (st.hasv) begin
                out_valid_d         = 1'b1;
                out_d.kind          = KIND_EDIT;
                out_d.edit_device   = st.key[47:16];
                out_d.edit_param    = st.key[15:0];
                out_d.before_value  = st.prior;
                out_d.after_value   = st.after;
                out_d.implicit_edit = 1'b1;
                nedit_d = nedit_q + 32'd1;
                stat_d[ST_EDITS]    = stat_q[ST_EDITS] + 32'd1;
                stat_d[ST_IMPLICIT] = stat_q[ST_IMPLICIT] + 32'd1;
              end
            end
          end
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        out_valid_d      = 1'b1;
        out_d.kind       = KIND_DRAIN;
        out_d.table_full = full_q;
        out_d.number     = nedit_q;
        out_d.last       = 1'b1;
        state_d          = S_IDLE;
      end

      S_OP_APPLY: begin
        cmd.op         = C_SEED_EXP;
        out_valid_d    = 1'b1;
        out_d.kind     = KIND_ACK;
        out_d.accepted = 1'b1;
        out_d.last     = 1'b1;
        state_d        = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      nedit_q     <= '0;
      full_q      <= 1'b0;
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= '0;
      for (int k = 0; k < NUM_STATS; k++) stat_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      nedit_q     <= nedit_d;
      full_q      <= full_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      stat_q      <= stat_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_QUIET:    cfg_q.quiet    <= cfg_wdata_i;
          REG_LIFETIME: cfg_q.lifetime <= cfg_wdata_i;
          REG_TOL:      cfg_q.tol      <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
    if (ring_we) begin
      ring_key_q[wp_q] <= {in_item_i.device_id, in_item_i.param_index};
      ring_pay_q[wp_q] <= {in_item_i.event_kind, in_item_i.param_value};
    end
  end

endmodule

@@ sv/pec_checker.sv @@
`include "assert_macros.svh"

module pec_checker import pec_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input in_item_t  in_item_i,
  input logic      busy,
  input logic      out_valid_o,
  input out_item_t out_item_o
);

  logic push_in, push_out, edit_out, drain_out;

  assign push_in   = start && !busy && (in_item_i.op == OP_PUSH);
  assign push_out  = out_valid_o && (out_item_o.kind == KIND_PUSH) && out_item_o.last;
  assign edit_out  = out_valid_o && (out_item_o.kind == KIND_EDIT);
  assign drain_out = out_valid_o && (out_item_o.kind == KIND_DRAIN);

  // A push is answered with its status in the very next cycle.
  `ASSERT_CLK(push_answered, clk_i, rst_ni, push_in |=> push_out)
  // Edits are never the final result of a drain.
  `ASSERT_NEVER(edit_is_last, clk_i, rst_ni, edit_out && out_item_o.last)
  // The drain summary always closes the item.
  `ASSERT_CLK(drain_done_last, clk_i, rst_ni, drain_out |-> out_item_o.last)
  // The block only becomes busy right after taking an item.
  `ASSERT_CLK(busy_after_start, clk_i, rst_ni, $rose(busy) |-> $past(start))

endmodule

bind param_edit_coalescer pec_checker u_pec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .in_item_i   (in_item_i),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o)
);
